[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the statistics monitor RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");

// The expression must never be true at a rising clock edge outside reset.
`define ASSERT_NEVER(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("forbidden condition seen");

`endif

[src/rsm_pkg.sv]
// ----------------------------------------------------------------------------
// Runtime statistics monitor package
// Shared constants and item kind codes of the statistics monitor.
// ----------------------------------------------------------------------------
package rsm_pkg;

    localparam int SAMPLE_WIDTH_DEF     = 32;
    localparam int POLL_COUNT_WIDTH_DEF = 16;

    localparam int KIND_W       = 2;
    localparam int FIELD_W      = 32;
    localparam int POLL_FIELD_W = 16;
    localparam int OUT_DATA_W   = 8 * FIELD_W + POLL_FIELD_W;

    localparam logic [KIND_W-1:0] KIND_RUN   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_POLL  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

endpackage

[src/rsm_div.sv]
// ----------------------------------------------------------------------------
// Restoring divider
// Unsigned divider that produces one quotient bit per cycle; a zero divisor
// yields a zero quotient.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rsm_div #(
    parameter int WIDTH = rsm_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [WIDTH-1:0] num,
    input  logic [WIDTH-1:0] den,
    output logic             done,
    output logic [WIDTH-1:0] quot
);

    localparam int CNT_W = $clog2(WIDTH);

    logic             busy_reg;
    logic             done_reg;
    logic             zero_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [WIDTH-1:0] rem_reg;
    logic [WIDTH-1:0] quo_reg;
    logic [WIDTH-1:0] den_reg;
    logic [WIDTH:0]   shifted;
    logic [WIDTH:0]   diff;

    assign shifted = {rem_reg, quo_reg[WIDTH-1]};
    assign diff    = shifted - {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(WIDTH - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= '0;
            quo_reg  <= num;
            den_reg  <= den;
            zero_reg <= (den == '0);
        end else if (busy_reg) begin
            rem_reg <= diff[WIDTH] ? shifted[WIDTH-1:0] : diff[WIDTH-1:0];
            quo_reg <= {quo_reg[WIDTH-2:0], ~diff[WIDTH]};
        end
    end

    assign done = done_reg;
    assign quot = zero_reg ? '0 : quo_reg;

    `ASSERT_CLK(a_div_done_after_busy, aclk, aresetn, done_reg |-> $past(busy_reg))
    `ASSERT_CLK(a_div_start_busy, aclk, aresetn, start |=> busy_reg && !done_reg)

endmodule

[src/runtime_statistics_monitor_top.sv]
// ----------------------------------------------------------------------------
// Runtime statistics monitor
// Keeps maxima, sums and counts of runtime and poll-time samples and reports
// them with the two averages after every input transaction.
// ----------------------------------------------------------------------------
// Usage: each input transaction carries a sample in s_axis_tdata and its kind
// in s_axis_tuser (runtime sample, poll-time sample or clear of the current
// maxima; the fourth code changes nothing). Every input transaction yields
// exactly one output transaction holding both maxima of each side, the
// averages and the counters.
// Steps: a prepare step and an apply step update the statistics, then one
// shared restoring divider produces the runtime average and then the poll
// average, one quotient bit per cycle.
// Input: the block is not ready while an item is being processed, so it
// takes a new input transaction only after the previous one is finished.
// Reset: aresetn is synchronous and active low; all statistics clear to zero
// and no output is pending.
// Stall: the result sits in an output register, so the next item is taken
// while it waits; a further result waits in the final step until the
// receiver has taken the previous one.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module runtime_statistics_monitor_top #(
    parameter int SAMPLE_WIDTH     = rsm_pkg::SAMPLE_WIDTH_DEF,
    parameter int POLL_COUNT_WIDTH = rsm_pkg::POLL_COUNT_WIDTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // sample[31:0]
    input  logic [rsm_pkg::FIELD_W-1:0]     s_axis_tdata,
    // kind[1:0]
    input  logic [rsm_pkg::KIND_W-1:0]      s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // max_runtime[31:0], max_runtime_ever[63:32], avg_runtime[95:64],
    // runtime_count[127:96], runtime_lost_count[159:128], max_polltime[191:160],
    // max_polltime_ever[223:192], avg_polltime[255:224], poll_count[271:256]
    output logic [rsm_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

    localparam int SW    = SAMPLE_WIDTH;
    localparam int PW    = POLL_COUNT_WIDTH;
    localparam int DIV_W = (SW > PW) ? SW : PW;
    localparam int FW    = rsm_pkg::FIELD_W;
    localparam int PFW   = rsm_pkg::POLL_FIELD_W;

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_PREP     = 7'b0000010,
        S_APPLY    = 7'b0000100,
        S_DEN      = 7'b0001000,
        S_DIV_RUN  = 7'b0010000,
        S_DIV_POLL = 7'b0100000,
        S_DONE     = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [rsm_pkg::KIND_W-1:0] kind_reg;
    logic [SW-1:0]              sample_reg;
    logic [SW-1:0]              live_reg;
    logic                       ovf_reg;

    logic [SW-1:0] run_max_reg, run_max_next;
    logic [SW-1:0] run_hist_reg, run_hist_next;
    logic [SW-1:0] run_sum_reg, run_sum_next;
    logic [SW-1:0] run_count_reg, run_count_next;
    logic [SW-1:0] run_lost_reg, run_lost_next;
    logic [SW-1:0] poll_max_reg, poll_max_next;
    logic [SW-1:0] poll_hist_reg, poll_hist_next;
    logic [SW-1:0] poll_sum_reg, poll_sum_next;
    logic [PW-1:0] poll_cnt_reg, poll_cnt_next;
    logic [DIV_W-1:0] avg_run_reg;

    logic                          m_valid_reg;
    logic [rsm_pkg::OUT_DATA_W-1:0] m_data_reg;

    logic [SW:0]   run_add;
    logic [SW:0]   poll_add;
    logic [SW-1:0] run_live;
    logic [SW-1:0] run_base;
    logic [SW-1:0] poll_base;
    logic [SW-1:0] poll_sum_add;
    logic [PW:0]   poll_cnt_add;
    logic [SW-1:0] run_ever;
    logic [SW-1:0] poll_ever;
    logic          out_free;

    logic             div_start;
    logic [DIV_W-1:0] div_num;
    logic [DIV_W-1:0] div_den;
    logic             div_done;
    logic [DIV_W-1:0] div_quot;

    rsm_div #(
        .WIDTH (DIV_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quot    (div_quot)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign out_free      = !m_valid_reg || m_axis_tready;

    assign run_add      = {1'b0, run_sum_reg} + {1'b0, sample_reg};
    assign poll_add     = {1'b0, poll_sum_reg} + {1'b0, sample_reg};
    assign run_live     = run_count_reg - run_lost_reg;
    assign run_base     = ovf_reg ? (run_sum_reg >> 1) : run_sum_reg;
    assign poll_base    = ovf_reg ? (poll_sum_reg >> 1) : poll_sum_reg;
    assign poll_sum_add = poll_base + sample_reg;
    assign poll_cnt_add = {1'b0, (ovf_reg ? (poll_cnt_reg >> 1) : poll_cnt_reg)}
                          + (PW + 1)'(1);
    assign run_ever     = (run_max_reg > run_hist_reg) ? run_max_reg : run_hist_reg;
    assign poll_ever    = (poll_max_reg > poll_hist_reg) ? poll_max_reg : poll_hist_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:     if (s_axis_tvalid) state_next = S_PREP;
            S_PREP:     state_next = S_APPLY;
            S_APPLY:    state_next = S_DEN;
            S_DEN:      state_next = S_DIV_RUN;
            S_DIV_RUN:  if (div_done) state_next = S_DIV_POLL;
            S_DIV_POLL: if (div_done) state_next = S_DONE;
            S_DONE:     if (out_free) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb begin
        div_start = 1'b0;
        div_num   = DIV_W'(run_sum_reg);
        div_den   = DIV_W'(run_live);
        if (state_reg == S_DEN) begin
            div_start = 1'b1;
        end else if (state_reg == S_DIV_RUN && div_done) begin
            div_start = 1'b1;
            div_num   = DIV_W'(poll_sum_reg);
            div_den   = DIV_W'(poll_cnt_reg);
        end
    end

    always_comb begin
        run_max_next   = run_max_reg;
        run_hist_next  = run_hist_reg;
        run_sum_next   = run_sum_reg;
        run_count_next = run_count_reg;
        run_lost_next  = run_lost_reg;
        poll_max_next  = poll_max_reg;
        poll_hist_next = poll_hist_reg;
        poll_sum_next  = poll_sum_reg;
        poll_cnt_next  = poll_cnt_reg;
        if (state_reg == S_APPLY) begin
            unique case (kind_reg)
                rsm_pkg::KIND_RUN: begin
                    if (sample_reg > run_max_reg) run_max_next = sample_reg;
                    run_sum_next   = run_base + sample_reg;
                    run_count_next = run_count_reg + SW'(1);
                    if (ovf_reg) run_lost_next = run_lost_reg + (live_reg >> 1);
                end
                rsm_pkg::KIND_POLL: begin
                    if (sample_reg > poll_max_reg) poll_max_next = sample_reg;
                    if (poll_cnt_add[PW]) begin
                        poll_sum_next = poll_sum_add >> 1;
                        poll_cnt_next = {1'b1, {(PW - 1){1'b0}}};
                    end else begin
                        poll_sum_next = poll_sum_add;
                        poll_cnt_next = poll_cnt_add[PW-1:0];
                    end
                end
                rsm_pkg::KIND_CLEAR: begin
                    run_hist_next  = run_ever;
                    poll_hist_next = poll_ever;
                    run_max_next   = '0;
                    poll_max_next  = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            run_max_reg   <= '0;
            run_hist_reg  <= '0;
            run_sum_reg   <= '0;
            run_count_reg <= '0;
            run_lost_reg  <= '0;
            poll_max_reg  <= '0;
            poll_hist_reg <= '0;
            poll_sum_reg  <= '0;
            poll_cnt_reg  <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            run_max_reg   <= run_max_next;
            run_hist_reg  <= run_hist_next;
            run_sum_reg   <= run_sum_next;
            run_count_reg <= run_count_next;
            run_lost_reg  <= run_lost_next;
            poll_max_reg  <= poll_max_next;
            poll_hist_reg <= poll_hist_next;
            poll_sum_reg  <= poll_sum_next;
            poll_cnt_reg  <= poll_cnt_next;
            if (state_reg == S_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            kind_reg   <= s_axis_tuser;
            sample_reg <= SW'(s_axis_tdata);
        end
        if (state_reg == S_PREP) begin
            live_reg <= run_live;
            ovf_reg  <= (kind_reg == rsm_pkg::KIND_RUN) ? run_add[SW] : poll_add[SW];
        end
        if (state_reg == S_DIV_RUN && div_done) begin
            avg_run_reg <= div_quot;
        end
        if (state_reg == S_DONE && out_free) begin
            m_data_reg <= {PFW'(poll_cnt_reg), FW'(div_quot), FW'(poll_ever),
                           FW'(poll_max_reg), FW'(run_lost_reg), FW'(run_count_reg),
                           FW'(avg_run_reg), FW'(run_ever), FW'(run_max_reg)};
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    `ASSERT_CLK(a_accept_starts_item, aclk, aresetn,
                s_axis_tvalid && s_axis_tready |=> state_reg == S_PREP)
    `ASSERT_CLK(a_poll_cnt_nonzero, aclk, aresetn,
                state_reg == S_APPLY && kind_reg == rsm_pkg::KIND_POLL |=> poll_cnt_reg != '0)
    `ASSERT_CLK(a_result_from_done, aclk, aresetn,
                $rose(m_valid_reg) |-> $past(state_reg == S_DONE))
    `ASSERT_NEVER(a_no_overwrite, aclk, aresetn,
                  state_reg == S_DONE && m_valid_reg && !m_axis_tready && state_next == S_IDLE)

endmodule
